@@ rtl/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/mm_pkg.sv @@
`timescale 1ns / 1ps

package mm_pkg;

    typedef logic [1:0]        mode_t;
    typedef logic [1:0]        index_t;
    typedef logic signed [31:0] value_t;
    typedef logic [2:0]        size_t;
    typedef logic [1:0]        cfg_index_t;

    localparam mode_t MODE_LOAD_FIRST  = 2'd0;
    localparam mode_t MODE_LOAD_SECOND = 2'd1;
    localparam mode_t MODE_START       = 2'd2;

    localparam cfg_index_t CFG_FIRST_ROWS  = 2'd0;
    localparam cfg_index_t CFG_INNER_SIZE  = 2'd1;
    localparam cfg_index_t CFG_SECOND_COLS = 2'd2;

    localparam size_t SIZE_RESET = 3'd4;

    localparam int VALUE_W   = 32;
    localparam int PROD_W    = 64;
    localparam int FRAC_BITS = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

@@ rtl/mm_in_if.sv @@
`timescale 1ns / 1ps

interface mm_in_if;
    logic           valid;
    logic           ready;
    mm_pkg::mode_t  mode;
    mm_pkg::index_t element_row;
    mm_pkg::index_t element_col;
    mm_pkg::value_t element_value;

    modport source (output valid, mode, element_row, element_col, element_value,
                    input ready);
    modport sink   (input valid, mode, element_row, element_col, element_value,
                    output ready);
endinterface

@@ rtl/mm_out_if.sv @@
`timescale 1ns / 1ps

interface mm_out_if;
    logic           valid;
    logic           ready;
    mm_pkg::index_t result_row;
    mm_pkg::index_t result_col;
    mm_pkg::value_t result_value;
    logic           saturated;
    logic           last;

    modport source (output valid, result_row, result_col, result_value, saturated, last,
                    input ready);
    modport sink   (input valid, result_row, result_col, result_value, saturated, last,
                    output ready);
endinterface

@@ rtl/mm_cfg_if.sv @@
`timescale 1ns / 1ps

interface mm_cfg_if;
    logic                 valid;
    logic                 ready;
    mm_pkg::cfg_index_t   index;
    mm_pkg::size_t        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/mm_ram.sv @@
`timescale 1ns / 1ps

module mm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/matrix_multiply.sv @@
`timescale 1ns / 1ps
// Channel  | Dir  | Beat contents
// ---------+------+------------------------------------------------------------
// item     | in   | mode, element_row, element_col, element_value (Q16.16)
// result   | out  | result_row, result_col, result_value (Q16.16), saturated, last
// cfg      | in   | index (0 first_rows, 1 inner_size, 2 second_cols), data
//
// A load beat leaves the block ready again the next cycle.
// A start beat runs the whole product while the block is busy:
// one shared 32x32 multiplier and one accumulator step through the dot products.
// Reset clears both stores through per-entry valid bits, so no clearing pass runs.
// A waiting result stalls only the step that finishes the next dot product; the
// last result may wait in the output register while new loads are taken.

module matrix_multiply #(
    parameter int MAX_DIM = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    mm_in_if.sink           item,
    mm_out_if.source        result,
    mm_cfg_if.sink          cfg
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int SW    = $clog2(MAX_DIM + 1);
    // Exact sum of MAX_DIM products of two 32-bit values, with a sign bit to spare.
    localparam int ACC_W = mm_pkg::PROD_W + DW + 1;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh0000_0000_7fff_ffff);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(64'shffff_ffff_8000_0000);

    // Clamp a size register to 1..MAX_DIM; the register keeps the written bits.
    function automatic logic [SW-1:0] eff_size(input mm_pkg::size_t v);
        logic [SW-1:0] s;
        if (v == 3'd0)
        begin
            s = SW'(1);
        end
        else if (32'(v) > 32'(MAX_DIM))
        begin
            s = SW'(MAX_DIM);
        end
        else
        begin
            s = SW'(v);
        end
        return s;
    endfunction

    // Size registers
    mm_pkg::size_t first_rows_reg, inner_size_reg, second_cols_reg;
    logic [SW-1:0] m_eff, k_eff, n_eff;

    // Sequencer
    mm_pkg::state_t state_reg, state_next;
    logic [DW-1:0]  r_reg, r_next, c_reg, c_next, i_reg, i_next;

    // Stores
    logic [DEPTH-1:0] a_vld_reg, a_vld_next, b_vld_reg, b_vld_next;
    logic             a_rvld_reg, b_rvld_reg;
    logic             a_we, b_we;
    logic [AW-1:0]    waddr, a_raddr, b_raddr;
    logic [31:0]      a_rdata, b_rdata;

    // MAC pipeline
    logic                           rd_v_reg, prod_v_reg;
    logic signed [31:0]             a_val, b_val;
    logic signed [mm_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]        acc_reg, acc_next, shifted;

    // Output register
    logic            out_valid_reg, out_valid_next;
    mm_pkg::index_t  out_row_reg, out_col_reg;
    mm_pkg::value_t  out_value_reg, out_value_next;
    logic            out_sat_reg, out_sat_next, out_last_reg, out_last_next;

    logic item_fire, start_fire, done_fire, last_elem;

    assign m_eff = eff_size(first_rows_reg);
    assign k_eff = eff_size(inner_size_reg);
    assign n_eff = eff_size(second_cols_reg);

    assign item.ready = (state_reg == mm_pkg::ST_IDLE);
    assign cfg.ready  = 1'b1;
    assign item_fire  = item.valid && item.ready;
    assign start_fire = item_fire && (item.mode == mm_pkg::MODE_START);

    //------------------------------------------------------------------
    // Configuration
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_rows_reg  <= mm_pkg::SIZE_RESET;
            inner_size_reg  <= mm_pkg::SIZE_RESET;
            second_cols_reg <= mm_pkg::SIZE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                mm_pkg::CFG_FIRST_ROWS:  first_rows_reg  <= cfg.data;
                mm_pkg::CFG_INNER_SIZE:  inner_size_reg  <= cfg.data;
                mm_pkg::CFG_SECOND_COLS: second_cols_reg <= cfg.data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    //------------------------------------------------------------------
    // Loads: write a store only inside the current size of its matrix
    //------------------------------------------------------------------
    assign waddr = AW'(32'(item.element_row) * 32'(MAX_DIM) + 32'(item.element_col));
    assign a_we  = item_fire && (item.mode == mm_pkg::MODE_LOAD_FIRST)
                   && (32'(item.element_row) < 32'(m_eff))
                   && (32'(item.element_col) < 32'(k_eff));
    assign b_we  = item_fire && (item.mode == mm_pkg::MODE_LOAD_SECOND)
                   && (32'(item.element_row) < 32'(k_eff))
                   && (32'(item.element_col) < 32'(n_eff));

    always_comb
    begin
        a_vld_next = a_vld_reg;
        b_vld_next = b_vld_reg;
        if (a_we)
        begin
            a_vld_next[waddr] = 1'b1;
        end
        if (b_we)
        begin
            b_vld_next[waddr] = 1'b1;
        end
    end

    // Read addresses follow the counters: first[r][i] and second[i][c].
    assign a_raddr = AW'(32'(r_reg) * 32'(MAX_DIM) + 32'(i_reg));
    assign b_raddr = AW'(32'(i_reg) * 32'(MAX_DIM) + 32'(c_reg));

    mm_ram #(.WIDTH(mm_pkg::VALUE_W), .DEPTH(DEPTH)) u_first_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (item.element_value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mm_ram #(.WIDTH(mm_pkg::VALUE_W), .DEPTH(DEPTH)) u_second_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (item.element_value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    //------------------------------------------------------------------
    // Sequencer: walk r, c over the product and i over the inner dimension
    //------------------------------------------------------------------
    assign last_elem = (32'(r_reg) == 32'(m_eff) - 1) && (32'(c_reg) == 32'(n_eff) - 1);
    assign done_fire = (state_reg == mm_pkg::ST_DONE) && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        i_next     = i_reg;
        unique case (state_reg)
            mm_pkg::ST_IDLE:
            begin
                if (start_fire)
                begin
                    r_next     = '0;
                    c_next     = '0;
                    i_next     = '0;
                    state_next = mm_pkg::ST_MAC;
                end
            end
            mm_pkg::ST_MAC:
            begin
                // Issue one read pair per cycle.
                if (32'(i_reg) == 32'(k_eff) - 1)
                begin
                    i_next     = '0;
                    state_next = mm_pkg::ST_DRAIN;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            mm_pkg::ST_DRAIN:
            begin
                // Wait for the last product to reach the accumulator.
                if (!rd_v_reg && !prod_v_reg)
                begin
                    state_next = mm_pkg::ST_DONE;
                end
            end
            mm_pkg::ST_DONE:
            begin
                if (done_fire)
                begin
                    if (last_elem)
                    begin
                        state_next = mm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = mm_pkg::ST_MAC;
                        if (32'(c_reg) == 32'(n_eff) - 1)
                        begin
                            c_next = '0;
                            r_next = r_reg + 1'b1;
                        end
                        else
                        begin
                            c_next = c_reg + 1'b1;
                        end
                    end
                end
            end
            default: state_next = mm_pkg::ST_IDLE;
        endcase
    end

    //------------------------------------------------------------------
    // Shared multiply-accumulate unit
    //------------------------------------------------------------------
    // A never-written entry reads as zero.
    assign a_val     = a_rvld_reg ? $signed(a_rdata) : 32'sd0;
    assign b_val     = b_rvld_reg ? $signed(b_rdata) : 32'sd0;
    assign prod_next = a_val * b_val;

    always_comb
    begin
        acc_next = acc_reg;
        if (start_fire || done_fire)
        begin
            acc_next = '0;
        end
        else if (prod_v_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    // Drop 16 fraction bits with floor rounding, then clamp to 32 bits.
    assign shifted = acc_reg >>> mm_pkg::FRAC_BITS;

    always_comb
    begin
        if (shifted > SAT_HI)
        begin
            out_value_next = 32'sh7fff_ffff;
            out_sat_next   = 1'b1;
        end
        else if (shifted < SAT_LO)
        begin
            out_value_next = 32'sh8000_0000;
            out_sat_next   = 1'b1;
        end
        else
        begin
            out_value_next = shifted[31:0];
            out_sat_next   = 1'b0;
        end
        out_last_next = last_elem;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg         <= '0;
            c_reg         <= '0;
            i_reg         <= '0;
            a_vld_reg     <= '0;
            b_vld_reg     <= '0;
            rd_v_reg      <= 1'b0;
            prod_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            r_reg         <= r_next;
            c_reg         <= c_next;
            i_reg         <= i_next;
            a_vld_reg     <= a_vld_next;
            b_vld_reg     <= b_vld_next;
            rd_v_reg      <= (state_reg == mm_pkg::ST_MAC);
            prod_v_reg    <= rd_v_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge clk)
    begin
        a_rvld_reg <= a_vld_reg[a_raddr];
        b_rvld_reg <= b_vld_reg[b_raddr];
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        if (done_fire)
        begin
            out_row_reg   <= 2'(r_reg);
            out_col_reg   <= 2'(c_reg);
            out_value_reg <= out_value_next;
            out_sat_reg   <= out_sat_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.result_row   = out_row_reg;
    assign result.result_col   = out_col_reg;
    assign result.result_value = out_value_reg;
    assign result.saturated    = out_sat_reg;
    assign result.last         = out_last_reg;

endmodule

@@ rtl/mm_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mm_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           item_valid,
    input logic           item_ready,
    input mm_pkg::mode_t  item_mode,
    input logic           result_valid,
    input logic           result_ready,
    input mm_pkg::value_t result_value,
    input logic           result_saturated,
    input logic           result_last
);

    logic item_fire;
    logic start_fire;

    assign item_fire  = item_valid && item_ready;
    assign start_fire = item_fire && (item_mode == mm_pkg::MODE_START);

    // A start beat makes the block busy on the next cycle.
    `ASSERT_NEXT(a_start_busy, clk, rst_n, start_fire, !item_ready)
    // A load or unused beat leaves the block ready.
    `ASSERT_NEXT(a_load_ready, clk, rst_n, item_fire && !start_fire, item_ready)
    // While a non-final result waits, the product is still in progress.
    `ASSERT_SAME(a_mid_busy, clk, rst_n, result_valid && !result_last, !item_ready)
    // A clamped value is one of the two limits.
    `ASSERT_SAME(a_sat_limit, clk, rst_n, result_valid && result_saturated,
                 (result_value == 32'sh7fff_ffff) || (result_value == 32'sh8000_0000))
    // A stalled result beat holds.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, result_valid && !result_ready,
                 result_valid && $stable(result_value))

endmodule

bind matrix_multiply mm_checker u_mm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item.valid),
    .item_ready       (item.ready),
    .item_mode        (item.mode),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .result_value     (result.result_value),
    .result_saturated (result.saturated),
    .result_last      (result.last)
);
